FILE: rtl/core/rau_pkg.sv
// Rational arithmetic unit package: transaction structs, action codes, widths.
// Depends on nothing; used by every file in rtl/core.
package rau_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int DEN_WIDTH   = VALUE_WIDTH - 1;
    localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;
    localparam int MAG_WIDTH   = PROD_WIDTH + 1;
    localparam int CNT_WIDTH   = $clog2(MAG_WIDTH + 1);

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_LT  = 3'd4,
        ACT_EQ  = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_ERR = 2'd1,
        ST_OVF = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] a_num;
        logic [30:0]        a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } req_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               compare_true;
        logic [1:0]         status;
    } rsp_t;

endpackage

FILE: rtl/core/rau_mul.sv
// Iterative signed multiplier, one shift-add step per cycle.
// Depends on rau_pkg.
module rau_mul
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 go,
    input  logic signed [rau_pkg::VALUE_WIDTH-1:0] x,
    input  logic signed [rau_pkg::VALUE_WIDTH-1:0] y,
    output logic                                 done,
    output logic signed [rau_pkg::PROD_WIDTH-1:0]  prod
);

    logic [rau_pkg::PROD_WIDTH-1:0] acc_reg, acc_next;
    logic [rau_pkg::PROD_WIDTH-1:0] mcand_reg, mcand_next;
    logic [rau_pkg::VALUE_WIDTH-1:0] mplier_reg, mplier_next;
    logic                            neg_reg, neg_next;
    logic [rau_pkg::CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [rau_pkg::VALUE_WIDTH-1:0] xm, ym;

    always_comb
    begin
        xm          = x[rau_pkg::VALUE_WIDTH-1] ? -x : x;
        ym          = y[rau_pkg::VALUE_WIDTH-1] ? -y : y;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (go)
        begin
            acc_next    = '0;
            mcand_next  = {{rau_pkg::VALUE_WIDTH{1'b0}}, xm};
            mplier_next = ym;
            neg_next    = x[rau_pkg::VALUE_WIDTH-1] ^ y[rau_pkg::VALUE_WIDTH-1];
            cnt_next    = rau_pkg::CNT_WIDTH'(rau_pkg::VALUE_WIDTH);
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == rau_pkg::CNT_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        neg_reg    <= neg_next;
    end

    assign done = done_reg;
    assign prod = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);

endmodule

FILE: rtl/core/rational_arithmetic_unit.sv
// Rational arithmetic unit top level: sequencer, binary GCD and reduction.
// Depends on rau_pkg and rau_mul.
//
// Usage: drive req and pulse start while busy is low; the transaction is taken
// at that edge and busy rises. Each transaction yields exactly one result on
// rsp, marked by done for a single cycle; the receiver cannot stall it.
// Sequence: errors go straight to the output state, after which done rises.
// Otherwise three serial products on the shift-add multiplier, each launched
// from the wait state, a preparation state, a binary GCD of one step per cycle
// plus a final step that forms the GCD, two restoring divisions of 65 steps
// each on the shared subtract/shift path, then a state to form the result and
// one to present it, after which done rises. Compares follow the same path.
// One transaction at a time: busy stays high until the result cycle, and a
// new transaction may be taken in the cycle in which done is high.
// Reset clears the sequencer and drops any transaction in flight; no result
// is produced for it.
module rational_arithmetic_unit
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rau_pkg::req_t req,
    output logic          done,
    output rau_pkg::rsp_t rsp
);

    localparam int VW = rau_pkg::VALUE_WIDTH;
    localparam int DW = rau_pkg::DEN_WIDTH;
    localparam int PW = rau_pkg::PROD_WIDTH;
    localparam int MW = rau_pkg::MAG_WIDTH;
    localparam int CW = rau_pkg::CNT_WIDTH;
    localparam int KW = $clog2(MW + 1);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_M1   = 11'b00000000010,
        S_M2   = 11'b00000000100,
        S_M3   = 11'b00000001000,
        S_PREP = 11'b00000010000,
        S_GCD  = 11'b00000100000,
        S_DIVN = 11'b00001000000,
        S_DIVD = 11'b00010000000,
        S_FIN  = 11'b00100000000,
        S_OUT  = 11'b01000000000,
        S_WAIT = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]           act_reg;
    logic signed [VW-1:0] an_reg, bn_reg, ad_reg, bd_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg;
    logic [MW-1:0]        mag_reg, dm_reg, u_reg, v_reg, g_reg;
    logic [MW-1:0]        q_reg, r_reg, qn_reg;
    logic [KW-1:0]        k_reg;
    logic [CW-1:0]        bit_reg;
    logic                 neg_reg;
    rau_pkg::rsp_t        rsp_reg, rsp_next;
    logic                 done_reg;

    // Sequencer position within multiply phases is tracked with a phase counter.
    logic [1:0]           ph_reg;

    logic                 mul_go, mul_done;
    logic signed [VW-1:0] mx, my;
    logic signed [PW-1:0] mprod;

    logic [2:0]           in_act;
    logic signed [VW-1:0] in_an, in_bn;
    logic [DW-1:0]        in_ad, in_bd;
    logic                 in_err;
    logic signed [PW:0]   sum_w;
    logic [MW-1:0]        diff_w, rem_sh;
    logic [MW-1:0]        lim_w;

    assign in_act = req.action;
    assign in_an  = req.a_num[VW-1:0];
    assign in_bn  = req.b_num[VW-1:0];
    assign in_ad  = req.a_den[DW-1:0];
    assign in_bd  = req.b_den[DW-1:0];
    assign in_err = (in_ad == '0) || (in_bd == '0) || (in_act > rau_pkg::ACT_EQ)
                  || ((in_act == rau_pkg::ACT_DIV) && (in_bn == '0));

    rau_mul u_mul
    (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (mul_go),
        .x    (mx),
        .y    (my),
        .done (mul_done),
        .prod (mprod)
    );

    // Select operands by phase; the multiplier latches them when launched.
    always_comb
    begin
        mul_go = (state_reg == S_WAIT);
        case (ph_reg)
            2'd0:
            begin
                mx = an_reg;
                my = (act_reg == rau_pkg::ACT_MUL) ? bn_reg : bd_reg;
            end
            2'd1:
            begin
                mx = (act_reg == rau_pkg::ACT_DIV) ? an_reg : bn_reg;
                my = (act_reg == rau_pkg::ACT_DIV) ? bd_reg : ad_reg;
            end
            default:
            begin
                mx = ad_reg;
                my = (act_reg == rau_pkg::ACT_DIV) ? bn_reg : bd_reg;
            end
        endcase
    end

    assign sum_w  = (act_reg == rau_pkg::ACT_SUB) ? (PW+1)'(p1_reg) - (PW+1)'(p2_reg)
                                                   : (PW+1)'(p1_reg) + (PW+1)'(p2_reg);
    assign diff_w = (u_reg > v_reg) ? u_reg - v_reg : v_reg - u_reg;
    assign rem_sh = {r_reg[MW-2:0], qn_reg[MW-1]};
    assign lim_w  = MW'({DW{1'b1}});

    always_comb
    begin
        state_next = state_reg;
        rsp_next   = rsp_reg;
        unique case (state_reg)
            S_IDLE:
                if (start)
                    state_next = in_err ? S_OUT : S_WAIT;
            S_WAIT:
                state_next = S_M1;
            S_M1:
                if (mul_done)
                    state_next = S_WAIT;
            S_M2:
                if (mul_done)
                    state_next = S_WAIT;
            S_M3:
                if (mul_done)
                    state_next = S_PREP;
            S_PREP:
                state_next = S_GCD;
            S_GCD:
                if (v_reg == '0)
                    state_next = S_DIVN;
            S_DIVN:
                if (bit_reg == CW'(1))
                    state_next = S_DIVD;
            S_DIVD:
                if (bit_reg == CW'(1))
                    state_next = S_FIN;
            S_FIN:
                state_next = S_OUT;
            S_OUT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            ph_reg    <= '0;
        end
        else
        begin
            done_reg <= (state_reg == S_OUT);
            if (state_reg == S_WAIT)
            begin
                state_reg <= (ph_reg == 2'd0) ? S_M1 : (ph_reg == 2'd1) ? S_M2 : S_M3;
                ph_reg    <= ph_reg + 2'd1;
            end
            else if (state_reg == S_M1 || state_reg == S_M2)
            begin
                state_reg <= mul_done ? S_WAIT : state_reg;
            end
            else
            begin
                state_reg <= state_next;
                if (state_reg == S_IDLE)
                    ph_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg) inside
            S_IDLE:
                if (start)
                begin
                    act_reg <= in_act;
                    an_reg  <= in_an;
                    bn_reg  <= in_bn;
                    ad_reg  <= VW'(in_ad);
                    bd_reg  <= VW'(in_bd);
                    rsp_reg <= '{res_num: '0, res_den: '0, compare_true: 1'b0,
                                 status: rau_pkg::ST_ERR};
                end
            S_M1:
                if (mul_done)
                    p1_reg <= mprod;
            S_M2:
                if (mul_done)
                    p2_reg <= mprod;
            S_M3:
                if (mul_done)
                    p3_reg <= mprod;
            S_PREP:
            begin
                // numerator and denominator of the unreduced result
                if (act_reg == rau_pkg::ACT_MUL || act_reg == rau_pkg::ACT_DIV)
                begin
                    neg_reg <= p1_reg[PW-1] ^ p3_reg[PW-1];
                    mag_reg <= p1_reg[PW-1] ? MW'(-p1_reg) : MW'(p1_reg);
                    u_reg   <= p1_reg[PW-1] ? MW'(-p1_reg) : MW'(p1_reg);
                end
                else
                begin
                    neg_reg <= sum_w[PW] ^ p3_reg[PW-1];
                    mag_reg <= sum_w[PW] ? MW'(-sum_w) : MW'(sum_w);
                    u_reg   <= sum_w[PW] ? MW'(-sum_w) : MW'(sum_w);
                end
                dm_reg <= p3_reg[PW-1] ? MW'(-p3_reg) : MW'(p3_reg);
                v_reg  <= p3_reg[PW-1] ? MW'(-p3_reg) : MW'(p3_reg);
                k_reg  <= '0;
            end
            S_GCD:
            begin
                if (v_reg == '0)
                begin
                    g_reg   <= u_reg << k_reg;
                    qn_reg  <= mag_reg;
                    r_reg   <= '0;
                    bit_reg <= CW'(MW);
                end
                else if (u_reg == '0)
                begin
                    u_reg <= v_reg;
                    v_reg <= '0;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_reg <= u_reg >> 1;
                    v_reg <= v_reg >> 1;
                    k_reg <= k_reg + 1'b1;
                end
                else if (!u_reg[0])
                    u_reg <= u_reg >> 1;
                else if (!v_reg[0])
                    v_reg <= v_reg >> 1;
                else
                begin
                    u_reg <= (u_reg < v_reg) ? u_reg : v_reg;
                    v_reg <= diff_w >> 1;
                end
            end
            S_DIVN, S_DIVD:
            begin
                if (state_reg == S_DIVN && bit_reg == CW'(1))
                begin
                    q_reg   <= {qn_reg[MW-2:0], (rem_sh >= g_reg)};
                    qn_reg  <= dm_reg;
                    r_reg   <= '0;
                    bit_reg <= CW'(MW);
                end
                else
                begin
                    if (rem_sh >= g_reg)
                    begin
                        r_reg  <= rem_sh - g_reg;
                        qn_reg <= {qn_reg[MW-2:0], 1'b1};
                    end
                    else
                    begin
                        r_reg  <= rem_sh;
                        qn_reg <= {qn_reg[MW-2:0], 1'b0};
                    end
                    bit_reg <= bit_reg - 1'b1;
                end
            end
            S_FIN:
            begin
                if (act_reg == rau_pkg::ACT_LT || act_reg == rau_pkg::ACT_EQ)
                    rsp_reg <= '{res_num: '0, res_den: '0,
                                 compare_true: (act_reg == rau_pkg::ACT_LT)
                                     ? (p1_reg < p2_reg) : (p1_reg == p2_reg),
                                 status: rau_pkg::ST_OK};
                else if (mag_reg == '0)
                    rsp_reg <= '{res_num: '0, res_den: 31'd1, compare_true: 1'b0,
                                 status: rau_pkg::ST_OK};
                else if (qn_reg > lim_w || q_reg > (neg_reg ? lim_w + 1'b1 : lim_w))
                    rsp_reg <= '{res_num: '0, res_den: '0, compare_true: 1'b0,
                                 status: rau_pkg::ST_OVF};
                else
                    rsp_reg <= '{res_num: 32'(neg_reg ? -q_reg : q_reg),
                                 res_den: 31'(qn_reg), compare_true: 1'b0,
                                 status: rau_pkg::ST_OK};
            end
            default:
            begin
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_next;

    a_done_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> done)
        else $error("result strobe missing after output state");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == S_IDLE))
        else $error("result strobe outside idle");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transaction taken without busy");
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

endmodule

FILE: tb/tb.sv
// Testbench for rational_arithmetic_unit: directed and random fraction transactions
// checked against an in-bench model of add, subtract, multiply, divide and compares.
// Depends on rau_pkg and the rational_arithmetic_unit RTL.
`timescale 1ns / 1ps

module tb;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    rau_pkg::req_t req;
    logic done;
    rau_pkg::rsp_t rsp;

    rau_pkg::req_t pending_reqs[$];
    rau_pkg::rsp_t expected_rsps[$];
    int   error_count;
    bit   stim_done;
    int   burst_left;
    int   gap_left;

    rational_arithmetic_unit uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic rau_pkg::rsp_t reduce_fraction(input rau_pkg::req_t r);
        rau_pkg::rsp_t o;
        longint an, ad, bn, bd, n, d, l, rr;
        logic [63:0] mag, dm, g;
        bit neg;
        longint lim;
        an = longint'(r.a_num);
        bn = longint'(r.b_num);
        ad = longint'({1'b0, r.a_den});
        bd = longint'({1'b0, r.b_den});
        lim = 64'h7FFF_FFFF;
        o = '0;
        if (ad == 0 || bd == 0 || r.action > rau_pkg::ACT_EQ)
        begin
            o.status = rau_pkg::ST_ERR;
            return o;
        end
        if (r.action == rau_pkg::ACT_LT || r.action == rau_pkg::ACT_EQ)
        begin
            l = an * bd;
            rr = bn * ad;
            o.compare_true = (r.action == rau_pkg::ACT_LT) ? (l < rr) : (l == rr);
            o.status = rau_pkg::ST_OK;
            return o;
        end
        case (r.action)
            rau_pkg::ACT_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
            rau_pkg::ACT_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
            rau_pkg::ACT_MUL: begin n = an * bn; d = ad * bd; end
            default:
            begin
                if (bn == 0)
                begin
                    o.status = rau_pkg::ST_ERR;
                    return o;
                end
                n = an * bd;
                d = ad * bn;
            end
        endcase
        if (n == 0)
        begin
            o.res_den = 31'd1;
            return o;
        end
        neg = (n < 0) != (d < 0);
        mag = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        g = gcd64(mag, dm);
        mag = mag / g;
        dm = dm / g;
        if (dm > lim || mag > (neg ? lim + 1 : lim))
        begin
            o.status = rau_pkg::ST_OVF;
            return o;
        end
        o.res_num = neg ? -mag[31:0] : mag[31:0];
        o.res_den = dm[30:0];
        o.status = rau_pkg::ST_OK;
        return o;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic logic [31:0] rand_num();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20) - 10;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_den();
        case ($urandom_range(0, 5))
            0: return 31'($urandom_range(0, 12));
            1: return 31'h7FFF_FFFF - 31'($urandom_range(0, 2));
            2: return 31'($urandom_range(1, 3000));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic add_req(input logic [2:0] act, input logic [31:0] an, input logic [30:0] ad,
                           input logic [31:0] bn, input logic [30:0] bd);
        rau_pkg::req_t r;
        r.action = act;
        r.a_num = an;
        r.a_den = ad;
        r.b_num = bn;
        r.b_den = bd;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    initial
    begin
        logic [31:0] common;
        for (int a = 0; a < 8; a++)
        begin
            add_req(3'(a), 32'sd3, 31'd4, -32'sd5, 31'd6);
        end
        add_req(rau_pkg::ACT_ADD, 32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 31'd1);
        add_req(rau_pkg::ACT_MUL, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
        add_req(rau_pkg::ACT_MUL, 32'h8000_0000, 31'd1, 32'sd1, 31'd1);
        add_req(rau_pkg::ACT_DIV, 32'sd1, 31'h7FFF_FFFF, 32'sd0, 31'd1);
        add_req(rau_pkg::ACT_DIV, 32'sd1, 31'h7FFF_FFFF, -32'sd1, 31'h7FFF_FFFF);
        add_req(rau_pkg::ACT_SUB, 32'sd7, 31'd9, 32'sd7, 31'd9);
        add_req(rau_pkg::ACT_ADD, 32'sd1, 31'd0, 32'sd1, 31'd1);
        add_req(rau_pkg::ACT_LT, 32'sd1, 31'd1, 32'sd1, 31'd0);
        add_req(rau_pkg::ACT_EQ, 32'sd2, 31'd4, 32'sd1, 31'd2);
        add_req(rau_pkg::ACT_LT, 32'h8000_0000, 31'd1, 32'h7FFF_FFFF, 31'd1);
        add_req(rau_pkg::ACT_DIV, 32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000,
                31'h7FFF_FFFF);
        add_req(rau_pkg::ACT_MUL, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF,
                31'h7FFF_FFFF);
        add_req(rau_pkg::ACT_DIV, 32'h7FFF_FFFF, 31'd1, 32'h8000_0000, 31'd1);
        add_req(rau_pkg::ACT_LT, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h0, 31'h7FFF_FFFF);
        for (int i = 0; i < 1150; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                common = $urandom_range(1, 500);
                add_req(3'($urandom_range(0, 5)), rand_num() * common,
                        31'(common * $urandom_range(1, 900)),
                        rand_num(), 31'($urandom_range(1, 900) * common));
            end
            else
            begin
                add_req(($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                      : 3'($urandom_range(0, 5)),
                        rand_num(), rand_den(), rand_num(), rand_den());
            end
        end
        stim_done = 1'b1;
    end

    initial
    begin
        error_count = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (stim_done && pending_reqs.size() == 0 && expected_rsps.size() == 0);
        repeat (400) @(posedge clk);
        if (error_count == 0 && expected_rsps.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Driver: raise start for one cycle while idle, then drop it and advance.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start)
            begin
                start <= 1'b0;
            end
            else
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                end
                else if (pending_reqs.size() != 0 && !busy)
                begin
                    req <= pending_reqs[0];
                    start <= 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left <= burst_left - 1;
                    end
                    else
                    begin
                        burst_left <= $urandom_range(0, 8);
                        gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 300);
                    end
                end
            end
        end
        else
        begin
            start <= 1'b0;
            req <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
    end

    // Monitor: log accepted transactions and check results.
    always @(posedge clk)
    begin
        rau_pkg::rsp_t exp_rsp;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_rsps.insert(expected_rsps.size(),
                                     reduce_fraction(pending_reqs.pop_front()));
            end
            if (done)
            begin
                if (expected_rsps.size() == 0)
                begin
                    report_mismatch("result with no transaction outstanding");
                end
                else
                begin
                    exp_rsp = expected_rsps.pop_front();
                    if (rsp.res_num !== exp_rsp.res_num)
                        report_mismatch($sformatf("res_num %0d expected %0d",
                                                  rsp.res_num, exp_rsp.res_num));
                    if (rsp.res_den !== exp_rsp.res_den)
                        report_mismatch($sformatf("res_den %0d expected %0d",
                                                  rsp.res_den, exp_rsp.res_den));
                    if (rsp.compare_true !== exp_rsp.compare_true)
                        report_mismatch($sformatf("compare_true %0b expected %0b",
                                                  rsp.compare_true, exp_rsp.compare_true));
                    if (rsp.status !== exp_rsp.status)
                        report_mismatch($sformatf("status %0d expected %0d",
                                                  rsp.status, exp_rsp.status));
                end
            end
        end
    end

endmodule
